// File: rtl/core/ncw_pkg.sv
// Shared types, constants and helpers for the NewReno congestion window block.
// No dependencies; imported by every module under rtl/core.
package ncw_pkg;

	localparam int CNT_W  = 48;             // width of byte counts and window
	localparam int RTT_W  = 24;
	localparam int BYTE_W = 32;
	localparam int ACC_W  = 69;             // window times pacing scale
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	// event codes
	localparam logic [2:0] ACT_SENT      = 3'd0;
	localparam logic [2:0] ACT_ACKED     = 3'd1;
	localparam logic [2:0] ACT_DISCARDED = 3'd2;
	localparam logic [2:0] ACT_LOSS      = 3'd3;
	localparam logic [2:0] ACT_RTT       = 3'd4;

	// phase codes
	localparam logic [1:0] PH_SLOW     = 2'd0;
	localparam logic [1:0] PH_AVOID    = 2'd1;
	localparam logic [1:0] PH_RECOVERY = 2'd2;

	// register indexes (byte address = 8 * index)
	localparam logic [2:0] REG_MAX_DGRAM = 3'd0;
	localparam logic [2:0] REG_INIT_WIN  = 3'd1;
	localparam logic [2:0] REG_MIN_WIN   = 3'd2;
	localparam logic [2:0] REG_INIT_THR  = 3'd3;
	localparam logic [2:0] REG_INIT_RTT  = 3'd4;

	// reset values
	localparam logic [15:0]      RST_MAX_DGRAM = 16'd1472;
	localparam logic [23:0]      RST_INIT_WIN  = 24'd14720;
	localparam logic [19:0]      RST_MIN_WIN   = 20'd2944;
	localparam logic [CNT_W-1:0] RST_INIT_THR  = CNT_MAX;
	localparam logic [RTT_W-1:0] RST_INIT_RTT  = 24'd333000;

	// pacing scale: gain * 1e6, gain 5/4 in slow start
	localparam logic [MUL_B_W-1:0] PACE_K_SLOW = 24'd1250000;
	localparam logic [MUL_B_W-1:0] PACE_K_NORM = 24'd1000000;

	typedef struct packed {
		logic [2:0]        action;
		logic [BYTE_W-1:0] bytes;
		logic [RTT_W-1:0]  rtt_us;
	} ncw_req_t;

	typedef struct packed {
		logic [CNT_W-1:0] in_flight;
		logic [CNT_W-1:0] window;
		logic [CNT_W-1:0] threshold;
		logic [1:0]       phase;
		logic             below_window;
		logic             datagram_fits;
		logic [CNT_W-1:0] pacing_bytes_per_s;
		logic             pacing_unlimited;
	} ncw_rsp_t;

	typedef struct packed {
		logic [15:0]      max_datagram;
		logic [23:0]      initial_window;
		logic [19:0]      min_window;
		logic [CNT_W-1:0] initial_threshold;
		logic [RTT_W-1:0] initial_rtt_us;
	} ncw_cfg_t;

	// state reloads that ride along with some register writes
	typedef struct packed {
		logic window;
		logic threshold;
		logic rtt;
	} ncw_load_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sat_sub(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		return (b < a) ? (a - b) : '0;
	endfunction

endpackage

// File: rtl/core/ncw_regs.sv
// APB register file for the congestion window block.
// Depends on ncw_pkg.
module ncw_regs import ncw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output ncw_cfg_t          cfg,
	output ncw_load_t         load
);

	logic       wr;
	logic [2:0] idx;
	ncw_cfg_t   cfg_q;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[5:3];
	assign cfg    = cfg_q;

	always_comb begin
		load.window    = wr && (idx == REG_INIT_WIN);
		load.threshold = wr && (idx == REG_INIT_THR);
		load.rtt       = wr && (idx == REG_INIT_RTT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_datagram      <= RST_MAX_DGRAM;
			cfg_q.initial_window    <= RST_INIT_WIN;
			cfg_q.min_window        <= RST_MIN_WIN;
			cfg_q.initial_threshold <= RST_INIT_THR;
			cfg_q.initial_rtt_us    <= RST_INIT_RTT;
		end else if (wr) begin
			case (idx)
				REG_MAX_DGRAM: cfg_q.max_datagram      <= pwdata[15:0];
				REG_INIT_WIN:  cfg_q.initial_window    <= pwdata[23:0];
				REG_MIN_WIN:   cfg_q.min_window        <= pwdata[19:0];
				REG_INIT_THR:  cfg_q.initial_threshold <= pwdata[CNT_W-1:0];
				REG_INIT_RTT:  cfg_q.initial_rtt_us    <= pwdata[RTT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MAX_DGRAM: prdata = DATA_W'(cfg_q.max_datagram);
			REG_INIT_WIN:  prdata = DATA_W'(cfg_q.initial_window);
			REG_MIN_WIN:   prdata = DATA_W'(cfg_q.min_window);
			REG_INIT_THR:  prdata = DATA_W'(cfg_q.initial_threshold);
			REG_INIT_RTT:  prdata = DATA_W'(cfg_q.initial_rtt_us);
			default:       prdata = '0;
		endcase
	end

endmodule

// File: rtl/core/ncw_mul.sv
// Shared 32x24 multiplier with a registered product.
// Depends on ncw_pkg.
module ncw_mul import ncw_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic [MUL_P_W-1:0] p
);

	logic [MUL_P_W-1:0] p_q;

	assign p = p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// File: rtl/core/ncw_div.sv
// Restoring divider, one quotient bit per cycle.
// Remainder preload must be below the divisor. Depends on ncw_pkg.
module ncw_div import ncw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] divisor,
	input  logic [CNT_W-1:0] rem_init,
	input  logic [CNT_W-1:0] dividend,
	output logic             done,
	output logic [CNT_W-1:0] quotient
);

	localparam int CW = $clog2(CNT_W);
	localparam logic [CW-1:0] LAST = CW'(CNT_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [CNT_W-1:0] dq_q;   // dividend bits out at the top, quotient bits in at the bottom
	logic [CNT_W-1:0] dvs_q;
	logic [CNT_W:0]   trial;
	logic             ge;

	assign trial    = {rem_q, dq_q[CNT_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dq_q   <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= rem_init;
				dq_q   <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= ge ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
				dq_q  <= {dq_q[CNT_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/newreno_congestion_window.sv
// NewReno congestion window with pacing-rate report, top level.
// One request at a time: after accept the event updates apply, then avoidance growth
// (bytes times max_datagram, over window) if it applies, then the pacing product and its
// divide by rtt (skipped when rtt is zero or pacing saturates); then the response register
// loads. Both divides run on one shared radix-2 divider. A new request is taken from the
// cycle after the response loads, and the response waits while the response side stalls.
// Async active-low reset loads register defaults: window 14720, threshold 2^48-1, rtt
// 333000 us, slow start, nothing in flight. Depends on ncw_pkg, ncw_regs/mul/div.
module newreno_congestion_window import ncw_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  ncw_req_t          req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output ncw_rsp_t          rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,       // apply the event's simple updates
		ST_GROW_MUL,   // max_datagram * bytes
		ST_GROW_DIV,   // launch product / window
		ST_GROW_WAIT,
		ST_PACE_LO,    // window[23:0] * scale
		ST_PACE_HI,    // window[47:24] * scale
		ST_PACE_SUM,   // combine partial products
		ST_PACE_CHK,   // overflow check, launch divide by rtt
		ST_PACE_WAIT,
		ST_FINISH      // load response register
	} state_t;

	ncw_cfg_t  cfg;
	ncw_load_t load;

	state_t           state_q;
	ncw_req_t         req_q;
	logic [CNT_W-1:0] flight_q;
	logic [CNT_W-1:0] cwnd_q;
	logic [CNT_W-1:0] thr_q;
	logic [1:0]       phase_q;
	logic [RTT_W-1:0] srtt_q;
	logic [ACC_W-1:0] acc_q;
	logic [CNT_W-1:0] pace_q;
	logic             unl_q;
	logic             rsp_valid_q;
	ncw_rsp_t         rsp_q;

	// shared unit hookup
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] mul_p;
	logic               div_start;
	logic [CNT_W-1:0]   div_divisor;
	logic [CNT_W-1:0]   div_rem;
	logic [CNT_W-1:0]   div_dividend;
	logic               div_done;
	logic [CNT_W-1:0]   div_q;

	// event update terms
	logic [CNT_W-1:0] bytes_ext;
	logic [CNT_W-1:0] flight_dec;
	logic [CNT_W-1:0] half;
	logic [CNT_W-1:0] min_ext;
	logic [CNT_W-1:0] loss_win;
	logic             pace_ovf;
	logic             out_free;
	logic [CNT_W-1:0] room;

	ncw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.load    (load)
	);

	ncw_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	ncw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (div_divisor),
		.rem_init (div_rem),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_q)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign bytes_ext  = CNT_W'(req_q.bytes);
	assign flight_dec = sat_sub(flight_q, bytes_ext);
	assign half       = cwnd_q >> 1;
	assign min_ext    = CNT_W'(cfg.min_window);
	assign loss_win   = (half > min_ext) ? half : min_ext;
	// quotient reaches 2^48 when the bits above the low 48 already cover the divisor
	assign pace_ovf   = CNT_W'(acc_q[ACC_W-1:CNT_W]) >= CNT_W'(srtt_q);
	assign room       = cwnd_q - ((flight_q < cwnd_q) ? flight_q : cwnd_q);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = (phase_q == PH_SLOW) ? PACE_K_SLOW : PACE_K_NORM;
		case (state_q)
			ST_GROW_MUL: begin
				mul_a = req_q.bytes;
				mul_b = MUL_B_W'(cfg.max_datagram);
			end
			ST_PACE_LO: mul_a = MUL_A_W'(cwnd_q[23:0]);
			ST_PACE_HI: mul_a = MUL_A_W'(cwnd_q[CNT_W-1:24]);
			default: ;
		endcase
	end

	// divider launch: window growth, then pacing
	always_comb begin
		div_start    = 1'b0;
		div_divisor  = cwnd_q;
		div_rem      = '0;
		div_dividend = mul_p[CNT_W-1:0];
		case (state_q)
			ST_GROW_DIV: div_start = 1'b1;
			ST_PACE_CHK: begin
				div_start    = !pace_ovf;
				div_divisor  = CNT_W'(srtt_q);
				div_rem      = CNT_W'(acc_q[ACC_W-1:CNT_W]);
				div_dividend = acc_q[CNT_W-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= '0;
			flight_q    <= '0;
			cwnd_q      <= CNT_W'(RST_INIT_WIN);
			thr_q       <= RST_INIT_THR;
			phase_q     <= PH_SLOW;
			srtt_q      <= RST_INIT_RTT;
			acc_q       <= '0;
			pace_q      <= '0;
			unl_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// ST_FINISH sets valid itself when the slot frees
			if (rsp_valid_q && !rsp_stall && state_q != ST_FINISH)
				rsp_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					state_q <= ST_PACE_LO;
					case (req_q.action)
						ACT_SENT: flight_q <= sat_add(flight_q, bytes_ext);
						ACT_ACKED: begin
							flight_q <= flight_dec;
							if (phase_q == PH_RECOVERY) begin
								phase_q <= PH_AVOID;
							end else if (phase_q == PH_SLOW) begin
								cwnd_q <= sat_add(cwnd_q, bytes_ext);
							end else if (cwnd_q == '0) begin
								cwnd_q <= CNT_MAX;   // growth term taken as all ones
							end else begin
								state_q <= ST_GROW_MUL;
							end
						end
						ACT_DISCARDED: flight_q <= flight_dec;
						ACT_LOSS: begin
							// loss during recovery is ignored
							if (phase_q != PH_RECOVERY) begin
								flight_q <= flight_dec;
								thr_q    <= loss_win;
								cwnd_q   <= loss_win;
								phase_q  <= PH_RECOVERY;
							end
						end
						ACT_RTT: begin
							if (req_q.rtt_us != '0)
								srtt_q <= req_q.rtt_us;
						end
						default: ;   // query and unused codes
					endcase
				end

				ST_GROW_MUL: state_q <= ST_GROW_DIV;
				ST_GROW_DIV: state_q <= ST_GROW_WAIT;

				ST_GROW_WAIT: begin
					if (div_done) begin
						cwnd_q  <= sat_add(cwnd_q, (div_q == '0) ? CNT_W'(1) : div_q);
						state_q <= ST_PACE_LO;
					end
				end

				ST_PACE_LO: begin
					if (srtt_q == '0) begin
						pace_q  <= '0;
						unl_q   <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						unl_q   <= 1'b0;
						state_q <= ST_PACE_HI;
					end
				end

				ST_PACE_HI: begin
					acc_q   <= ACC_W'(mul_p);
					state_q <= ST_PACE_SUM;
				end

				ST_PACE_SUM: begin
					acc_q   <= (ACC_W'(mul_p) << 24) + acc_q;
					state_q <= ST_PACE_CHK;
				end

				ST_PACE_CHK: begin
					if (pace_ovf) begin
						pace_q  <= CNT_MAX;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_PACE_WAIT;
					end
				end

				ST_PACE_WAIT: begin
					if (div_done) begin
						pace_q  <= div_q;
						state_q <= ST_FINISH;
					end
				end

				ST_FINISH: begin
					if (out_free) begin
						rsp_q.in_flight          <= flight_q;
						rsp_q.window             <= cwnd_q;
						rsp_q.threshold          <= thr_q;
						rsp_q.phase              <= phase_q;
						rsp_q.below_window       <= bytes_ext < cwnd_q;
						rsp_q.datagram_fits      <= bytes_ext <= room;
						rsp_q.pacing_bytes_per_s <= pace_q;
						rsp_q.pacing_unlimited   <= unl_q;
						rsp_valid_q              <= 1'b1;
						state_q                  <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase

			// register writes that also reload live state (the user writes them only while idle; the block does not enforce it)
			if (load.window)
				cwnd_q <= CNT_W'(pwdata[23:0]);
			if (load.threshold)
				thr_q <= pwdata[CNT_W-1:0];
			if (load.rtt)
				srtt_q <= pwdata[RTT_W-1:0];
		end
	end

endmodule
